// ===== sv/wfd_pkg.sv =====
`timescale 1ns / 1ps
// wfd_pkg: shared types and codes of the wait-for deadlock detector
// no dependencies

package wfd_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int ID_WIDTH_DEF    = 32;
   localparam int OUT_ID_WIDTH    = 32;
   localparam int MAX_RESULTS     = 16;

   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_SET_CONN = 3'd1;
   localparam logic [2:0] OP_UNREG    = 3'd2;
   localparam logic [2:0] OP_WAIT     = 3'd3;
   localparam logic [2:0] OP_WAIT_END = 3'd4;
   localparam logic [2:0] OP_QUERY    = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOT_REG  = 3'd1;
   localparam logic [2:0] ST_DOUBLE   = 3'd2;
   localparam logic [2:0] ST_DEADLOCK = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_DISPATCH,
      S_TARGET,
      S_WALK,
      S_SCAN,
      S_PICK,
      S_EMIT,
      S_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture request
      logic scan_start;  // clear scan index
      logic scan_step;   // advance scan index
      logic look_tid;    // scan compares with trans id
      logic look_gid;    // scan compares with target id
      logic do_op;       // apply simple op effects
      logic wait_begin;  // start chain walk
      logic walk_step;   // one chain step
      logic unreg_mark;  // mark waiters during scan
      logic pick_start;
      logic pick_step;
      logic emit_sig;    // emit one signal result
      logic emit_self;   // emit self signal
      logic emit_done;   // emit completion
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic me_found;
      logic tg_found;
      logic walk_end;
      logic pick_found;
      logic sig_room;
      logic self_sig;
      logic is_wait;
      logic is_unreg;
   } stat_type;

endpackage

// ===== sv/wfd_ctrl.sv =====
`timescale 1ns / 1ps
// wfd_ctrl: sequencer of the detector
// depends on wfd_pkg

module wfd_ctrl
   import wfd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (start) state_in = S_LOOKUP;
         S_LOOKUP:   if (stat.scan_last) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (stat.is_wait && stat.me_found) state_in = S_TARGET;
            else if (stat.is_unreg && stat.me_found) state_in = S_SCAN;
            else state_in = S_DONE;
         end
         S_TARGET:   if (stat.scan_last) state_in = stat.tg_found ? S_WALK : S_DONE;
         S_WALK:     if (stat.walk_end) state_in = S_DONE;
         S_SCAN:     if (stat.scan_last) state_in = S_PICK;
         S_PICK:     if (stat.scan_last) state_in = S_EMIT;
         S_EMIT:     state_in = (stat.pick_found && stat.sig_room) ? S_PICK : S_DONE;
         // a pending self signal goes out first, then the completion
         S_DONE:     state_in = stat.self_sig ? S_DONE : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            cmd.load       = start;
            cmd.scan_start = start;
         end
         S_LOOKUP: begin
            cmd.look_tid   = 1'b1;
            cmd.scan_step  = 1'b1;
            cmd.scan_start = stat.scan_last;
         end
         S_DISPATCH: begin
            cmd.do_op      = 1'b1;
            cmd.scan_start = 1'b1;
         end
         S_TARGET: begin
            cmd.look_gid   = 1'b1;
            cmd.scan_step  = 1'b1;
            cmd.wait_begin = stat.scan_last;
         end
         S_WALK:     cmd.walk_step = 1'b1;
         S_SCAN: begin
            cmd.unreg_mark = 1'b1;
            cmd.scan_step  = 1'b1;
            cmd.scan_start = stat.scan_last;
            cmd.pick_start = stat.scan_last;
         end
         S_PICK: begin
            cmd.pick_step  = 1'b1;
            cmd.scan_step  = 1'b1;
            cmd.scan_start = stat.scan_last;
         end
         S_EMIT: begin
            cmd.emit_sig   = stat.pick_found && stat.sig_room;
         end
         S_DONE: begin
            cmd.emit_done  = !stat.self_sig;
            cmd.emit_self  = stat.self_sig;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== sv/wfd_datapath.sv =====
`timescale 1ns / 1ps
// wfd_datapath: transaction table, scan index, chain walker, result register
// depends on wfd_pkg

module wfd_datapath
   import wfd_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [2:0]              req_opcode,
   input  logic [ID_WIDTH-1:0]     req_trans_id,
   input  logic [ID_WIDTH-1:0]     req_target_id,
   input  logic                    req_signal_wanted,
   input  logic                    req_connection_present,
   output logic                    rsp_valid,
   output logic                    rsp_result_kind,
   output logic [OUT_ID_WIDTH-1:0] rsp_signalled_id,
   output logic [2:0]              rsp_status,
   output logic [OUT_ID_WIDTH-1:0] rsp_waiting_id,
   output logic                    rsp_last
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int WW = $clog2(TABLE_DEPTH + 1);
   localparam logic [WW-1:0] WAIT_NONE = WW'(TABLE_DEPTH);
   localparam int CW = $clog2(MAX_RESULTS);

   // table; ids and flags are undefined until written
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ID_WIDTH-1:0]    id_ff   [TABLE_DEPTH];
   logic [WW-1:0]          wait_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] conn_ff, want_ff, sig_ff;

   // request capture
   logic [2:0]          op_ff;
   logic [ID_WIDTH-1:0] tid_ff, gid_ff;
   logic                want_req_ff, conn_req_ff;

   // scan state
   logic [IW-1:0] idx_ff;
   logic          me_found_ff, tg_found_ff, free_found_ff;
   logic [IW-1:0] me_ff, tg_ff, free_ff, cur_ff, best_ff;
   logic [WW-1:0] steps_ff;
   logic          best_found_ff, first_ff;
   logic [ID_WIDTH-1:0] prev_ff;
   logic [CW-1:0] nsig_ff;
   logic [2:0]    status_ff;
   logic [ID_WIDTH-1:0] waiting_ff;
   logic          self_ff;

   logic scan_last;
   assign scan_last = (idx_ff == IW'(TABLE_DEPTH - 1));

   // walker view
   logic [WW-1:0] nx;
   logic          nx_ok, walk_end;
   assign nx       = wait_ff[cur_ff];
   assign nx_ok    = (nx < WAIT_NONE) && valid_ff[nx[IW-1:0]];
   assign walk_end = (cur_ff == me_ff) || !nx_ok || (steps_ff == WW'(TABLE_DEPTH));

   logic hit_id;
   assign hit_id = valid_ff[idx_ff] && (id_ff[idx_ff] == (cmd.look_tid ? tid_ff : gid_ff));

   assign stat.scan_last  = scan_last;
   assign stat.me_found   = me_found_ff;
   assign stat.tg_found   = tg_found_ff || (cmd.look_gid && hit_id && gid_ff != '0);
   assign stat.walk_end   = walk_end;
   assign stat.pick_found = best_found_ff;
   assign stat.sig_room   = (nsig_ff != CW'(MAX_RESULTS - 1));
   assign stat.self_sig   = self_ff;
   assign stat.is_wait    = (op_ff == OP_WAIT);
   assign stat.is_unreg   = (op_ff == OP_UNREG);

   // valid bits reset; set and cleared through valid_in
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   logic [WW-1:0] me_w;
   assign me_w = WW'(me_ff);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.do_op && op_ff == OP_REGISTER && tid_ff != '0 && !me_found_ff && free_found_ff)
         valid_in[free_ff] = 1'b1;
      if (cmd.emit_done && op_ff == OP_UNREG && me_found_ff)
         valid_in[me_ff] = 1'b0;
   end

   // main datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit_sig || cmd.emit_self || cmd.emit_done;
      end
      if (cmd.load) begin
         op_ff       <= req_opcode;
         tid_ff      <= req_trans_id;
         gid_ff      <= req_target_id;
         want_req_ff <= req_signal_wanted;
         conn_req_ff <= req_connection_present;
         me_found_ff <= 1'b0;
         tg_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         status_ff   <= ST_OK;
         waiting_ff  <= '0;
         self_ff     <= 1'b0;
         nsig_ff     <= '0;
         first_ff    <= 1'b1;
      end
      // index counter
      if (cmd.scan_start)     idx_ff <= '0;
      else if (cmd.scan_step) idx_ff <= idx_ff + 1'b1;
      // id lookup and free slot search
      if (cmd.look_tid) begin
         if (hit_id && tid_ff != '0 && !me_found_ff) begin
            me_found_ff <= 1'b1;
            me_ff       <= idx_ff;
         end
         if (!valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_ff       <= idx_ff;
         end
      end
      if (cmd.look_gid && hit_id && gid_ff != '0 && !tg_found_ff) begin
         tg_found_ff <= 1'b1;
         tg_ff       <= idx_ff;
      end
      // simple operations
      if (cmd.do_op) begin
         case (op_ff)
            OP_REGISTER: begin
               if (tid_ff == '0) status_ff <= ST_NOT_REG;
               else if (!me_found_ff) begin
                  if (!free_found_ff) status_ff <= ST_FULL;
                  else begin
                     id_ff[free_ff]   <= tid_ff;
                     wait_ff[free_ff] <= WAIT_NONE;
                     conn_ff[free_ff] <= 1'b0;
                     want_ff[free_ff] <= 1'b0;
                  end
               end
            end
            OP_SET_CONN: begin
               if (!me_found_ff) status_ff <= ST_NOT_REG;
               else conn_ff[me_ff] <= conn_req_ff;
            end
            OP_WAIT:     if (!me_found_ff) status_ff <= ST_NOT_REG;
            OP_WAIT_END: begin
               if (!me_found_ff) status_ff <= ST_NOT_REG;
               else wait_ff[me_ff] <= WAIT_NONE;
            end
            OP_QUERY: begin
               if (me_found_ff && wait_ff[me_ff] < WAIT_NONE
                   && valid_ff[wait_ff[me_ff][IW-1:0]])
                  waiting_ff <= id_ff[wait_ff[me_ff][IW-1:0]];
            end
            default: ;
         endcase
      end
      // target resolved: vanished, double wait or begin walk
      if (cmd.wait_begin) begin
         if (!stat.tg_found) begin
            if (conn_ff[me_ff] && want_req_ff) begin
               wait_ff[me_ff] <= WAIT_NONE;
               self_ff        <= 1'b1;
            end
         end else begin
            logic [IW-1:0] t;
            t = tg_found_ff ? tg_ff : idx_ff;
            tg_ff <= t;
            if (wait_ff[me_ff] != WAIT_NONE && wait_ff[me_ff] != WW'(t)) begin
               status_ff <= ST_DOUBLE;
               cur_ff    <= me_ff;  // walk ends at once
               steps_ff  <= WW'(TABLE_DEPTH);
            end else begin
               wait_ff[me_ff] <= WW'(t);
               want_ff[me_ff] <= want_req_ff;
               cur_ff         <= t;
               steps_ff       <= '0;
            end
         end
      end
      // chain walk
      if (cmd.walk_step) begin
         if (walk_end) begin
            if (cur_ff == me_ff && status_ff != ST_DOUBLE) begin
               wait_ff[me_ff] <= WAIT_NONE;
               status_ff      <= ST_DEADLOCK;
            end
         end else begin
            cur_ff   <= nx[IW-1:0];
            steps_ff <= steps_ff + 1'b1;
         end
      end
      // waiter scan
      if (cmd.unreg_mark) begin
         sig_ff[idx_ff] <= 1'b0;
         if (idx_ff != me_ff && valid_ff[idx_ff] && wait_ff[idx_ff] == me_w) begin
            wait_ff[idx_ff] <= WAIT_NONE;
            sig_ff[idx_ff]  <= conn_ff[idx_ff] && want_ff[idx_ff];
         end
      end
      // minimum search above previous id
      if (cmd.pick_start) best_found_ff <= 1'b0;
      if (cmd.pick_step) begin
         if (idx_ff == '0) best_found_ff <= 1'b0;
         if (sig_ff[idx_ff] && (first_ff || id_ff[idx_ff] > prev_ff) &&
             (idx_ff == '0 || !best_found_ff || id_ff[idx_ff] < id_ff[best_ff])) begin
            best_found_ff <= 1'b1;
            best_ff       <= idx_ff;
         end
      end
      // result register
      rsp_result_kind  <= 1'b1;
      rsp_signalled_id <= '0;
      rsp_status       <= status_ff;
      rsp_waiting_id   <= OUT_ID_WIDTH'(waiting_ff);
      rsp_last         <= 1'b1;
      if (cmd.emit_sig) begin
         rsp_result_kind  <= 1'b0;
         rsp_signalled_id <= OUT_ID_WIDTH'(id_ff[best_ff]);
         rsp_status       <= ST_OK;
         rsp_waiting_id   <= '0;
         rsp_last         <= 1'b0;
         prev_ff          <= id_ff[best_ff];
         first_ff         <= 1'b0;
         nsig_ff          <= nsig_ff + 1'b1;
         best_found_ff    <= 1'b0;
      end
      // self signal of a waiter whose target is gone
      if (cmd.emit_self) begin
         rsp_result_kind  <= 1'b0;
         rsp_signalled_id <= OUT_ID_WIDTH'(id_ff[me_ff]);
         rsp_status       <= ST_OK;
         rsp_waiting_id   <= '0;
         rsp_last         <= 1'b0;
         self_ff          <= 1'b0;
      end
   end

endmodule

// ===== sv/wait_for_deadlock_detector_core.sv =====
`timescale 1ns / 1ps
// wait_for_deadlock_detector_core: top level of the wait-for deadlock detector
// depends on wfd_pkg, wfd_ctrl, wfd_datapath
//
// usage:
//   a request transfer happens when start is high and busy is low; the request
//   fields req_* are sampled at that edge. results leave on rsp_* for one cycle
//   each, marked by rsp_valid; the receiver cannot stall them. every request
//   ends with one completion (rsp_result_kind 1, rsp_last 1), preceded by any
//   signal results in ascending id order.
// operation:
//   id lookup scans the table one entry a cycle; simple operations then
//   dispatch and complete. indicate wait adds a target scan of the table and
//   a chain walk, or a self signal when the target is gone.
//   unregister adds a waiter scan of the table, then one ordered search per
//   signal and one final search.
//   one request is worked at a time; busy is high until its completion.
// reset:
//   synchronous reset clears all valid bits at once; the table is empty.

module wait_for_deadlock_detector_core
   import wfd_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_opcode,
   input  logic [ID_WIDTH-1:0]     req_trans_id,
   input  logic [ID_WIDTH-1:0]     req_target_id,
   input  logic                    req_signal_wanted,
   input  logic                    req_connection_present,
   output logic                    rsp_valid,
   output logic                    rsp_result_kind,
   output logic [OUT_ID_WIDTH-1:0] rsp_signalled_id,
   output logic [2:0]              rsp_status,
   output logic [OUT_ID_WIDTH-1:0] rsp_waiting_id,
   output logic                    rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   wfd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   wfd_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_opcode             (req_opcode),
      .req_trans_id           (req_trans_id),
      .req_target_id          (req_target_id),
      .req_signal_wanted      (req_signal_wanted),
      .req_connection_present (req_connection_present),
      .rsp_valid              (rsp_valid),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_signalled_id       (rsp_signalled_id),
      .rsp_status             (rsp_status),
      .rsp_waiting_id         (rsp_waiting_id),
      .rsp_last               (rsp_last)
   );

   // a completion always ends the busy period
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("completion while still busy");

   // signal results never carry a status
   a_sig_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_kind) |-> (rsp_status == ST_OK && !rsp_last))
      else $error("bad signal result");

   // completion and last go together
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == rsp_result_kind))
      else $error("last and kind disagree");

endmodule

// ===== dv/wfd_checker.sv =====
`timescale 1ns / 1ps
// wfd_checker: predicts and checks the results of the wait-for deadlock detector
// depends on wfd_pkg; watches the request and result channels of the core

module wfd_checker
   import wfd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [2:0]              req_opcode,
   input  logic [31:0]             req_trans_id,
   input  logic [31:0]             req_target_id,
   input  logic                    req_signal_wanted,
   input  logic                    req_connection_present,
   input  logic                    rsp_valid,
   input  logic                    rsp_result_kind,
   input  logic [OUT_ID_WIDTH-1:0] rsp_signalled_id,
   input  logic [2:0]              rsp_status,
   input  logic [OUT_ID_WIDTH-1:0] rsp_waiting_id,
   input  logic                    rsp_last,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic        kind;
      logic [31:0] sig_id;
      logic [2:0]  status;
      logic [31:0] wait_id;
      logic        last;
   } result_type;

   result_type  result_q[$];
   logic        tbl_valid[DEPTH];
   logic [31:0] tbl_id[DEPTH];
   int          tbl_wait[DEPTH];
   logic        tbl_conn[DEPTH];
   logic        tbl_want[DEPTH];

   assign pending = result_q.size();

   function automatic int find_id(logic [31:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void push_result(logic kind, logic [31:0] sid, logic [2:0] st,
                                       logic [31:0] wid, logic lst);
      result_type r;
      r.kind = kind; r.sig_id = sid; r.status = st; r.wait_id = wid; r.last = lst;
      result_q.push_back(r);
   endfunction

   // apply one operation to the table and queue its expected results
   task automatic predict_op(logic [2:0] op, logic [31:0] tid, logic [31:0] gid,
                             logic want, logic conn);
      logic [2:0]  st;
      logic [31:0] wid;
      int          me, tg, slot, cur, steps, best, n;
      logic        sig[DEPTH];
      logic [31:0] prev;
      logic        first;
      st = ST_OK; wid = 0; n = 0;
      me = find_id(tid);
      case (op)
         OP_REGISTER: begin
            if (tid == 0) st = ST_NOT_REG;
            else if (me < 0) begin
               slot = -1;
               for (int i = DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
               if (slot < 0) st = ST_FULL;
               else begin
                  tbl_valid[slot] = 1; tbl_id[slot] = tid; tbl_wait[slot] = DEPTH;
                  tbl_conn[slot] = 0; tbl_want[slot] = 0;
               end
            end
         end
         OP_SET_CONN: begin
            if (me < 0) st = ST_NOT_REG; else tbl_conn[me] = conn;
         end
         OP_UNREG: begin
            if (me >= 0) begin
               for (int i = 0; i < DEPTH; i++) begin
                  sig[i] = 0;
                  if (i != me && tbl_valid[i] && tbl_wait[i] == me) begin
                     tbl_wait[i] = DEPTH;
                     sig[i] = tbl_conn[i] && tbl_want[i];
                  end
               end
               first = 1; prev = 0;
               while (n < MAX_RESULTS - 1) begin
                  best = -1;
                  for (int i = 0; i < DEPTH; i++)
                     if (sig[i] && (first || tbl_id[i] > prev) &&
                         (best < 0 || tbl_id[i] < tbl_id[best])) best = i;
                  if (best < 0) break;
                  push_result(1'b0, tbl_id[best], ST_OK, 0, 1'b0);
                  n++;
                  prev = tbl_id[best]; first = 0;
               end
               tbl_valid[me] = 0;
            end
         end
         OP_WAIT: begin
            if (me < 0) st = ST_NOT_REG;
            else begin
               tg = find_id(gid);
               if (tg < 0) begin
                  if (tbl_conn[me] && want) begin
                     tbl_wait[me] = DEPTH;
                     push_result(1'b0, tbl_id[me], ST_OK, 0, 1'b0);
                  end
               end else if (tbl_wait[me] != DEPTH && tbl_wait[me] != tg) st = ST_DOUBLE;
               else begin
                  tbl_wait[me] = tg; tbl_want[me] = want;
                  cur = tg; steps = 0;
                  while (cur >= 0 && cur != me && steps < DEPTH) begin
                     if (tbl_wait[cur] < DEPTH && tbl_valid[tbl_wait[cur]]) cur = tbl_wait[cur];
                     else cur = -1;
                     steps++;
                  end
                  if (cur == me) begin
                     tbl_wait[me] = DEPTH; st = ST_DEADLOCK;
                  end
               end
            end
         end
         OP_WAIT_END: begin
            if (me < 0) st = ST_NOT_REG; else tbl_wait[me] = DEPTH;
         end
         OP_QUERY: begin
            if (me >= 0 && tbl_wait[me] < DEPTH && tbl_valid[tbl_wait[me]])
               wid = tbl_id[tbl_wait[me]];
         end
         default: ;
      endcase
      push_result(1'b1, 0, st, wid, 1'b1);
   endtask

   // predict on request transfer, compare on result strobe
   always @(posedge clock) begin
      result_type exp_r;
      result_type got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tbl_valid[i] <= 0;
         result_q = {};
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            got = {rsp_result_kind, rsp_signalled_id, rsp_status, rsp_waiting_id, rsp_last};
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = result_q.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch kind %0d/%0d sig %h/%h status %0d/%0d wait %h/%h last %0d/%0d",
                           $time, exp_r.kind, got.kind, exp_r.sig_id, got.sig_id,
                           exp_r.status, got.status, exp_r.wait_id, got.wait_id,
                           exp_r.last, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            predict_op(req_opcode, req_trans_id, req_target_id, req_signal_wanted,
                       req_connection_present);
      end
   end

endmodule

// ===== dv/wait_for_deadlock_detector_core_tb.sv =====
`timescale 1ns / 1ps
// wait_for_deadlock_detector_core_tb: stimulus and verdict for the deadlock detector
// depends on wfd_pkg, wait_for_deadlock_detector_core and wfd_checker

module wait_for_deadlock_detector_core_tb;
   import wfd_pkg::*;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    start = 0;
   logic                    busy;
   logic [2:0]              req_opcode = 0;
   logic [31:0]             req_trans_id = 0;
   logic [31:0]             req_target_id = 0;
   logic                    req_signal_wanted = 0;
   logic                    req_connection_present = 0;
   logic                    rsp_valid, rsp_result_kind, rsp_last;
   logic [OUT_ID_WIDTH-1:0] rsp_signalled_id, rsp_waiting_id;
   logic [2:0]              rsp_status;
   int                      fail_count, pending;
   int                      cycle_count = 0;
   logic [31:0]             id_pool[24];

   localparam int CYCLE_LIMIT = 600000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   wait_for_deadlock_detector_core i_dut (
      .clock, .reset, .start, .busy, .req_opcode, .req_trans_id, .req_target_id,
      .req_signal_wanted, .req_connection_present, .rsp_valid, .rsp_result_kind,
      .rsp_signalled_id, .rsp_status, .rsp_waiting_id, .rsp_last
   );

   wfd_checker i_checker (.*);

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request transfer, start held until accepted; the caller lowers start
   task automatic send_op(logic [2:0] op, logic [31:0] tid, logic [31:0] gid,
                          logic want, logic conn);
      start <= 1; req_opcode <= op; req_trans_id <= tid; req_target_id <= gid;
      req_signal_wanted <= want; req_connection_present <= conn;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_id();
      if ($urandom_range(0, 15) == 0) return $urandom();
      if ($urandom_range(0, 30) == 0) return 0;
      return id_pool[$urandom_range(0, 23)];
   endfunction

   initial begin
      int burst;
      logic [2:0] op;
      for (int i = 0; i < 24; i++) id_pool[i] = (i < 2) ? (i == 0 ? 32'hFFFF_FFFF : 1) : $urandom();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, every op and special cases
      send_op(OP_REGISTER, 0, 0, 0, 0);
      send_op(OP_REGISTER, 32'hFFFF_FFFF, 0, 0, 0);
      send_op(OP_REGISTER, 32'hFFFF_FFFF, 0, 0, 0);
      send_op(OP_REGISTER, 1, 0, 0, 0);
      send_op(OP_SET_CONN, 1, 0, 0, 1);
      send_op(OP_SET_CONN, 7, 0, 0, 1);
      send_op(OP_WAIT, 1, 32'hFFFF_FFFF, 1, 0);
      send_op(OP_QUERY, 1, 0, 0, 0);
      send_op(OP_WAIT, 1, 32'h1234, 1, 0);
      send_op(OP_WAIT, 32'hFFFF_FFFF, 1, 1, 0);
      send_op(OP_WAIT, 1, 1, 1, 0);
      send_op(OP_REGISTER, 5, 0, 0, 0);
      send_op(OP_WAIT, 1, 5, 1, 0);
      send_op(OP_WAIT, 1, 0, 1, 0);
      send_op(OP_WAIT_END, 1, 0, 0, 0);
      send_op(OP_WAIT_END, 9, 0, 0, 0);
      send_op(OP_WAIT, 1, 32'hFFFF_FFFF, 1, 0);
      send_op(OP_UNREG, 32'hFFFF_FFFF, 0, 0, 0);
      send_op(OP_UNREG, 32'h77, 0, 0, 0);
      send_op(3'd6, 1, 1, 1, 1);
      send_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
      for (int i = 2; i < 20; i++) send_op(OP_REGISTER, id_pool[i], 0, 0, 0);

      // random: mostly registered ids, lots of waits with connections
      for (int n = 0; n < 440; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < 440; b++, n++) begin
            case ($urandom_range(0, 19))
               0, 1, 2:       op = OP_REGISTER;
               3, 4, 5:       op = OP_SET_CONN;
               6, 7:          op = OP_UNREG;
               8, 9, 10, 11, 12, 13: op = OP_WAIT;
               14, 15:        op = OP_WAIT_END;
               16, 17, 18:    op = OP_QUERY;
               default:       op = 3'($urandom_range(0, 7));
            endcase
            send_op(op, pick_id(), pick_id(), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 2) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 60)) @(negedge clock);
         end
      end

      start <= 0;
      wait (pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
